@@ design/mbet_pkg.sv @@
// mbet_pkg: shared types and constants for the escape-time block
// controller state, command and status structs; no dependencies
`default_nettype none

package mbet_pkg;

  localparam int COORD_W = 32;
  localparam int COUNT_W = 10;

  localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 10'd511;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_HOLD
  } mbet_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture c, start z = c, clear count
    logic mul_en;    // register x*x, y*y, x*y
    logic step;      // z = z^2 + c, count + 1
    logic out_load;  // copy count into the result register
  } mbet_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic escape;    // |z|^2 >= 4 from registered products
    logic at_limit;  // count has reached max_iterations
  } mbet_status_t;

endpackage

`default_nettype wire

@@ design/mbet_ctrl.sv @@
// mbet_ctrl: controller state machine for the escape-time block
// depends on mbet_pkg; drives mbet_datapath through command struct
`default_nettype none

module mbet_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  mbet_pkg::mbet_status_t status,
  output mbet_pkg::mbet_cmd_t   cmd
);
  import mbet_pkg::*;

  mbet_state_t state;
  mbet_state_t state_next;
  logic        out_free;
  logic        finish;
  logic        out_valid_next;

  assign out_free = !out_valid || out_ready;

  // iteration ends on the limit before a multiply, or on escape after it
  always_comb begin
    finish = 1'b0;
    unique case (state)
      ST_MUL:  finish = status.at_limit;
      ST_CHK:  finish = status.escape;
      default: finish = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (!finish) state_next = ST_CHK;
        else if (out_free) state_next = ST_IDLE;
        else state_next = ST_HOLD;
      end
      ST_CHK: begin
        if (!finish) state_next = ST_MUL;
        else if (out_free) state_next = ST_IDLE;
        else state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL: begin
        cmd.mul_en   = !finish;
        cmd.out_load = finish && out_free;
      end
      ST_CHK: begin
        cmd.step     = !finish;
        cmd.out_load = finish && out_free;
      end
      ST_HOLD: begin
        cmd.out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ design/mbet_datapath.sv @@
// mbet_datapath: z registers, product registers, counter and result register
// depends on mbet_pkg; commanded by mbet_ctrl
`default_nettype none

module mbet_datapath #(
  parameter int FRAC_BITS = 28
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_write,
  input  wire  [mbet_pkg::COUNT_W-1:0]       cfg_data,
  input  wire  signed [mbet_pkg::COORD_W-1:0] c_real,
  input  wire  signed [mbet_pkg::COORD_W-1:0] c_imag,
  input  mbet_pkg::mbet_cmd_t                cmd,
  output mbet_pkg::mbet_status_t             status,
  output logic [mbet_pkg::COUNT_W-1:0]       iteration_count
);
  import mbet_pkg::*;

  localparam int PROD_W = 2 * COORD_W;
  localparam logic signed [PROD_W:0] LIMIT = (PROD_W+1)'(4) <<< FRAC_BITS;

  logic [COUNT_W-1:0]        max_iter;
  logic signed [COORD_W-1:0] c_re;
  logic signed [COORD_W-1:0] c_im;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic signed [PROD_W-1:0]  xx;
  logic signed [PROD_W-1:0]  yy;
  logic signed [PROD_W-1:0]  xy;
  logic [COUNT_W-1:0]        count;

  logic signed [PROD_W-1:0]  x2;
  logic signed [PROD_W-1:0]  y2;
  logic signed [PROD_W-1:0]  xy2;
  logic signed [PROD_W:0]    mag;
  logic signed [COORD_W-1:0] x_next;
  logic signed [COORD_W-1:0] y_next;

  // flooring shifts back to the fixed-point scale
  assign x2  = xx >>> FRAC_BITS;
  assign y2  = yy >>> FRAC_BITS;
  assign xy2 = xy >>> (FRAC_BITS - 1);
  assign mag = {x2[PROD_W-1], x2} + {y2[PROD_W-1], y2};

  // new parts wrap to 32 bits
  assign x_next = x2[COORD_W-1:0] - y2[COORD_W-1:0] + c_re;
  assign y_next = xy2[COORD_W-1:0] + c_im;

  assign status.escape   = (mag >= LIMIT);
  assign status.at_limit = (count >= max_iter);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= MAX_ITER_RESET;
    end else if (cfg_write) begin
      max_iter <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_re  <= c_real;
      c_im  <= c_imag;
      x     <= c_real;
      y     <= c_imag;
      count <= '0;
    end else if (cmd.step) begin
      x     <= x_next;
      y     <= y_next;
      count <= count + COUNT_W'(1);
    end
    if (cmd.mul_en) begin
      xx <= x * x;
      yy <= y * y;
      xy <= x * y;
    end
    if (cmd.out_load) begin
      iteration_count <= count;
    end
  end

endmodule

`default_nettype wire

@@ design/mandelbrot_escape_time.sv @@
// mandelbrot_escape_time: top level of the fixed-point escape-time block
// depends on mbet_pkg, mbet_ctrl and mbet_datapath
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   input    | in_valid / in_ready    | c_real, c_imag (signed, 32 bits)
//   output   | out_valid / out_ready  | iteration_count (10 bits)
//   config   | cfg_valid / cfg_ready  | max_iterations (10 bits)
//
// one point at a time, each iteration a multiply step, then a test and
// update step; a point ends on escape at a test, or on reaching the
// iteration limit before a multiply; the reset limit is 511
// rst is synchronous: the limit returns to 511 and no result is pending
// the result waits in an output register; a stalled output holds only the
// next finished point, input is taken again once that register frees
`default_nettype none

module mandelbrot_escape_time #(
  parameter int FRAC_BITS = 28
) (
  input  wire                                clk,
  input  wire                                rst,
  // point input
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  signed [mbet_pkg::COORD_W-1:0] c_real,
  input  wire  signed [mbet_pkg::COORD_W-1:0] c_imag,
  // result output
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [mbet_pkg::COUNT_W-1:0]       iteration_count,
  // iteration limit register
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [mbet_pkg::COUNT_W-1:0]       max_iterations
);
  import mbet_pkg::*;

  mbet_cmd_t    cmd;
  mbet_status_t status;

  // the limit register accepts a write on any cycle
  assign cfg_ready = 1'b1;

  mbet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mbet_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_data        (max_iterations),
    .c_real          (c_real),
    .c_imag          (c_imag),
    .cmd             (cmd),
    .status          (status),
    .iteration_count (iteration_count)
  );

endmodule

`default_nettype wire
